// File: src/kmrq_pkg.sv
// Package for the keyed message retry queue.
// Holds the command codes, the beat and slot types and the default depth.
// No dependencies.
package kmrq_pkg;

	localparam int unsigned QueueDepthDefault = 64;

	localparam logic [1:0] CMD_ENQ  = 2'd0;
	localparam logic [1:0] CMD_PEEK = 2'd1;
	localparam logic [1:0] CMD_DEQ  = 2'd2;
	localparam logic [1:0] CMD_CLR  = 2'd3;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [31:0] seq_num;
		logic [31:0]        ip_addr;
		logic [15:0]        peer_port;
		logic [63:0]        payload;
	} item_t;

	typedef struct packed {
		logic [31:0] seq_num;
		logic [31:0] ip_addr;
		logic [15:0] peer_port;
		logic [63:0] payload;
	} slot_t;

endpackage

// File: src/kmrq_front.sv
// Front end of the keyed message retry queue: a two-entry command queue.
// Depends on kmrq_pkg.
module kmrq_front
	import kmrq_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	output logic  item_valid,
	output item_t item,
	input  logic  pop
);

	item_t      buf_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	assign full       = (fill_q == 2'd2);
	assign item_valid = (fill_q != 2'd0);
	assign item       = buf_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop && item_valid) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			fill_q <= fill_q + 2'(push && !full) - 2'(pop && item_valid);
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			buf_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// File: src/kmrq_back.sv
// Back end of the keyed message retry queue: slot memory, key scan and compaction.
// Depends on kmrq_pkg.
module kmrq_back
	import kmrq_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  item_t       item,
	output logic        pop,
	output logic        done,
	output logic        found,
	output logic [63:0] payload_out,
	output logic        replaced_oldest,
	output logic [6:0]  entry_count,
	output logic        is_empty
);

	localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_COMP = 3'b100
	} state_t;

	state_t        state_q, state_d;
	slot_t         mem_q [QUEUE_DEPTH];
	slot_t         rd_data_s1;
	slot_t         wr_data;
	logic [AW-1:0] rd_addr, wr_addr, chk_q, src_q;
	logic          wr_en;
	logic [CW-1:0] cnt_q;
	logic [1:0]    cmd_q;
	slot_t         key_q;
	logic          done_q, found_q, repl_q;
	logic [63:0]   pay_q;
	logic          is_full, hit, chk_last, src_last;

	assign is_full  = (cnt_q == CW'(QUEUE_DEPTH));
	assign hit      = (rd_data_s1.seq_num == key_q.seq_num) &&
	                  (rd_data_s1.ip_addr == key_q.ip_addr) &&
	                  (rd_data_s1.peer_port == key_q.peer_port);
	assign chk_last = ((CW'(chk_q) + CW'(1)) == cnt_q);
	assign src_last = ((CW'(src_q) + CW'(1)) == cnt_q);

	always_comb begin
		state_d = state_q;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = src_q - AW'(1);
		wr_data = rd_data_s1;
		pop     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					pop = 1'b1;
					if (item.cmd == CMD_ENQ) begin
						wr_en   = 1'b1;
						wr_addr = is_full ? '0 : cnt_q[AW-1:0];
						wr_data = '{$unsigned(item.seq_num), item.ip_addr, item.peer_port,
						            item.payload};
					end else if ((item.cmd == CMD_PEEK || item.cmd == CMD_DEQ) &&
					             cnt_q != '0) begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (hit) begin
					if (cmd_q == CMD_PEEK || chk_last) begin
						state_d = ST_IDLE;
					end else begin
						state_d = ST_COMP;
						rd_addr = chk_q + AW'(1);
					end
				end else if (chk_last) begin
					state_d = ST_IDLE;
				end else begin
					rd_addr = chk_q + AW'(1);
				end
			end
			ST_COMP: begin
				wr_en = 1'b1;
				if (src_last) begin
					state_d = ST_IDLE;
				end else begin
					rd_addr = src_q + AW'(1);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_s1 <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						cmd_q   <= item.cmd;
						key_q   <= '{$unsigned(item.seq_num), item.ip_addr, item.peer_port,
						             64'd0};
						found_q <= 1'b0;
						pay_q   <= '0;
						repl_q  <= (item.cmd == CMD_ENQ) && is_full;
						chk_q   <= '0;
						case (item.cmd)
							CMD_ENQ: begin
								done_q <= 1'b1;
								if (!is_full) begin
									cnt_q <= cnt_q + CW'(1);
								end
							end
							CMD_CLR: begin
								done_q <= 1'b1;
								cnt_q  <= '0;
							end
							default: begin
								done_q <= (cnt_q == '0);
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (hit) begin
						found_q <= 1'b1;
						pay_q   <= rd_data_s1.payload;
						if (cmd_q == CMD_PEEK) begin
							done_q <= 1'b1;
						end else if (chk_last) begin
							done_q <= 1'b1;
							cnt_q  <= cnt_q - CW'(1);
						end else begin
							src_q <= chk_q + AW'(1);
						end
					end else if (chk_last) begin
						done_q <= 1'b1;
					end else begin
						chk_q <= chk_q + AW'(1);
					end
				end
				ST_COMP: begin
					if (src_last) begin
						done_q <= 1'b1;
						cnt_q  <= cnt_q - CW'(1);
					end else begin
						src_q <= src_q + AW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign done            = done_q;
	assign found           = found_q;
	assign payload_out     = pay_q;
	assign replaced_oldest = repl_q;
	assign entry_count     = 7'(cnt_q);
	assign is_empty        = (cnt_q == '0);

endmodule

// File: src/keyed_message_retry_queue_core.sv
// Keyed message retry queue: enqueue with overwrite of the oldest, keyed peek,
// keyed dequeue with order-preserving compaction, clear.
// Peek and dequeue walk the memory in a one-slot-per-cycle scan, which a
// dequeue carries on from the matching slot as compaction. A two-beat command queue
// takes commands while the back end works; busy rises when it is full.
// Reset clears the count and control state at once; done cannot be stalled.
module keyed_message_retry_queue_core
	import kmrq_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         cmd,
	input  logic signed [31:0] seq_num,
	input  logic [31:0]        ip_addr,
	input  logic [15:0]        peer_port,
	input  logic [63:0]        payload_in,
	output logic               done,
	output logic               found,
	output logic [63:0]        payload_out,
	output logic               replaced_oldest,
	output logic [6:0]         entry_count,
	output logic               is_empty
);

	item_t push_item, item;
	logic  item_valid, pop;

	assign push_item = '{cmd, seq_num, ip_addr, peer_port, payload_in};

	kmrq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (start),
		.push_item  (push_item),
		.full       (busy),
		.item_valid (item_valid),
		.item       (item),
		.pop        (pop)
	);

	kmrq_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item            (item),
		.pop             (pop),
		.done            (done),
		.found           (found),
		.payload_out     (payload_out),
		.replaced_oldest (replaced_oldest),
		.entry_count     (entry_count),
		.is_empty        (is_empty)
	);

endmodule

// File: src/kmrq_checker.sv
// Port-level checker for the keyed message retry queue, bound to the top level.
// Depends on keyed_message_retry_queue_core.
module kmrq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        done,
	input logic        found,
	input logic [63:0] payload_out,
	input logic        replaced_oldest,
	input logic [6:0]  entry_count,
	input logic        is_empty
);

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !found |-> payload_out == 64'd0)
		else $error("payload not zero on a miss");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && is_empty |-> entry_count == 7'd0)
		else $error("empty flag with entries held");

	a_repl_nohit: assert property (@(posedge clk) disable iff (!arst_n)
		done && replaced_oldest |-> !found && !is_empty)
		else $error("overwrite reported with a hit or empty queue");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !done)
		else $error("result beat straight after reset");

endmodule

bind keyed_message_retry_queue_core kmrq_checker u_kmrq_checker (.*);

// File: verif/keyed_message_retry_queue_core_tb.sv
// Self-checking testbench for the keyed message retry queue core.
// A directed table and random command beats are checked against a queue predictor.
// Depends on kmrq_pkg and keyed_message_retry_queue_core.
`timescale 1ns / 100ps

module keyed_message_retry_queue_core_tb;
	import kmrq_pkg::*;

	localparam int unsigned DEPTH = QueueDepthDefault;
	localparam int RANDOM_BEATS = 320;

	typedef struct packed {
		logic        found;
		logic [63:0] payload;
		logic        replaced;
		logic [6:0]  count;
		logic        empty;
	} outcome_t;

	typedef struct {
		logic [1:0]  cmd;
		logic [31:0] seq;
		logic [31:0] ip;
		logic [15:0] port;
		logic [63:0] data;
		bit          typed;
		outcome_t    want;
	} row_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         cmd;
	logic signed [31:0] seq_num;
	logic [31:0]        ip_addr;
	logic [15:0]        peer_port;
	logic [63:0]        payload_in;
	logic               done;
	logic               found;
	logic [63:0]        payload_out;
	logic               replaced_oldest;
	logic [6:0]         entry_count;
	logic               is_empty;

	slot_t    held_slots[$];
	outcome_t pending_outcomes[$];
	int       errors;
	row_t     rows[$];

	keyed_message_retry_queue_core #(.QUEUE_DEPTH(DEPTH)) dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("Regression FAIL");
		$finish;
	end

	function automatic outcome_t apply_command(input logic [1:0] c, input logic [31:0] s,
			input logic [31:0] a, input logic [15:0] p, input logic [63:0] d);
		outcome_t r;
		slot_t    e;
		int       hit;
		r = '0;
		hit = -1;
		e = '{seq_num: s, ip_addr: a, peer_port: p, payload: d};
		case (c)
			CMD_ENQ: begin
				if (held_slots.size() >= DEPTH) begin
					held_slots[0] = e;
					r.replaced = 1'b1;
				end else begin
					held_slots.push_back(e);
				end
			end
			CMD_PEEK, CMD_DEQ: begin
				foreach (held_slots[i])
					if (hit < 0 && held_slots[i].seq_num == s && held_slots[i].ip_addr == a
							&& held_slots[i].peer_port == p)
						hit = i;
				if (hit >= 0) begin
					r.found = 1'b1;
					r.payload = held_slots[hit].payload;
					if (c == CMD_DEQ)
						held_slots.delete(hit);
				end
			end
			default: held_slots.delete();
		endcase
		r.count = 7'(held_slots.size());
		r.empty = held_slots.size() == 0;
		return r;
	endfunction

	task automatic send_beat(input logic [1:0] c, input logic [31:0] s, input logic [31:0] a,
			input logic [15:0] p, input logic [63:0] d, input bit typed, input outcome_t want);
		outcome_t r;
		int       gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		seq_num <= s;
		ip_addr <= a;
		peer_port <= p;
		payload_in <= d;
		do
			@(posedge clk);
		while (busy);
		r = apply_command(c, s, a, p, d);
		if (typed && r != want) begin
			$error("table row disagrees with predictor");
			errors++;
		end
		pending_outcomes.push_back(r);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		outcome_t w;
		if (arst_n && done) begin
			if (pending_outcomes.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				w = pending_outcomes.pop_front();
				if (found !== w.found) begin
					$error("found: expected %0h, got %0h", w.found, found);
					errors++;
				end
				if (payload_out !== w.payload) begin
					$error("payload_out: expected %0h, got %0h", w.payload, payload_out);
					errors++;
				end
				if (replaced_oldest !== w.replaced) begin
					$error("replaced_oldest: expected %0h, got %0h", w.replaced, replaced_oldest);
					errors++;
				end
				if (entry_count !== w.count) begin
					$error("entry_count: expected %0h, got %0h", w.count, entry_count);
					errors++;
				end
				if (is_empty !== w.empty) begin
					$error("is_empty: expected %0h, got %0h", w.empty, is_empty);
					errors++;
				end
			end
		end
	end

	function automatic outcome_t oc(logic f, logic [63:0] d, logic rp, logic [6:0] n);
		return '{found: f, payload: d, replaced: rp, count: n, empty: n == 0};
	endfunction

	function automatic row_t mk(logic [1:0] c, logic [31:0] s, logic [31:0] a, logic [15:0] p,
			logic [63:0] d, bit t, outcome_t w);
		return '{cmd: c, seq: s, ip: a, port: p, data: d, typed: t, want: w};
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	initial begin
		logic [1:0]  c;
		logic [31:0] s, a;
		logic [15:0] p;
		int          pick, bias;
		errors = 0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_ENQ;
		seq_num = '0;
		ip_addr = '0;
		peer_port = '0;
		payload_in = '0;
		rows.push_back(mk(CMD_PEEK, 0, 0, 0, 0, 1, oc(0, 0, 0, 0)));
		rows.push_back(mk(CMD_DEQ, 0, 0, 0, 0, 1, oc(0, 0, 0, 0)));
		rows.push_back(mk(CMD_CLR, 0, 0, 0, 0, 1, oc(0, 0, 0, 0)));
		rows.push_back(mk(CMD_ENQ, 32'h8000_0000, '1, '1, '1, 1, oc(0, 0, 0, 1)));
		rows.push_back(mk(CMD_ENQ, 32'h7fff_ffff, 0, 0, 0, 1, oc(0, 0, 0, 2)));
		rows.push_back(mk(CMD_ENQ, 32'h8000_0000, '1, '1, 64'h5a5a, 1, oc(0, 0, 0, 3)));
		rows.push_back(mk(CMD_PEEK, 32'h8000_0000, '1, '1, 0, 1, oc(1, '1, 0, 3)));
		rows.push_back(mk(CMD_PEEK, 32'h8000_0000, '1, 16'hfffe, 0, 1, oc(0, 0, 0, 3)));
		rows.push_back(mk(CMD_DEQ, 32'h8000_0000, '1, '1, 0, 1, oc(1, '1, 0, 2)));
		rows.push_back(mk(CMD_DEQ, 32'h8000_0000, '1, '1, 0, 1, oc(1, 64'h5a5a, 0, 1)));
		rows.push_back(mk(CMD_DEQ, 32'h8000_0000, '1, '1, 0, 1, oc(0, 0, 0, 1)));
		rows.push_back(mk(CMD_DEQ, 32'h7fff_ffff, 0, 0, 0, 1, oc(1, 0, 0, 0)));
		rows.push_back(mk(CMD_ENQ, 1, 2, 3, 64'h1234, 1, oc(0, 0, 0, 1)));
		rows.push_back(mk(CMD_CLR, 0, 0, 0, 0, 1, oc(0, 0, 0, 0)));
		for (int i = 0; i < DEPTH; i++)
			rows.push_back(mk(CMD_ENQ, i, 32'hc0a8_0000, 7, 64'h100 + i, 0, '0));
		rows.push_back(mk(CMD_ENQ, 99, 1, 1, 64'hdead, 1, oc(0, 0, 1, 7'(DEPTH))));
		rows.push_back(mk(CMD_PEEK, 0, 32'hc0a8_0000, 7, 0, 1, oc(0, 0, 0, 7'(DEPTH))));
		rows.push_back(mk(CMD_DEQ, 5, 32'hc0a8_0000, 7, 0, 0, '0));
		rows.push_back(mk(CMD_DEQ, 99, 1, 1, 0, 0, '0));
		rows.push_back(mk(CMD_PEEK, DEPTH - 1, 32'hc0a8_0000, 7, 0, 0, '0));
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i])
			send_beat(rows[i].cmd, rows[i].seq, rows[i].ip, rows[i].port, rows[i].data,
				rows[i].typed, rows[i].want);
		drain();
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			bias = (n / 100) % 2;
			pick = $urandom_range(0, 99);
			if (pick < (bias ? 40 : 55))
				c = CMD_ENQ;
			else if (pick < 75)
				c = CMD_PEEK;
			else if (pick < 98)
				c = CMD_DEQ;
			else
				c = CMD_CLR;
			if (c != CMD_ENQ && held_slots.size() != 0 && $urandom_range(0, 3) != 0) begin
				pick = $urandom_range(0, held_slots.size() - 1);
				s = held_slots[pick].seq_num;
				a = held_slots[pick].ip_addr;
				p = held_slots[pick].peer_port;
				if ($urandom_range(0, 7) == 0)
					p ^= 16'h1 << $urandom_range(0, 15);
			end else if ($urandom_range(0, 1)) begin
				s = $urandom_range(0, 7);
				a = $urandom_range(0, 3);
				p = 16'($urandom_range(0, 3));
			end else begin
				s = $urandom();
				a = $urandom();
				p = 16'($urandom());
			end
			send_beat(c, s, a, p, rand64(), 0, '0);
			if (n == RANDOM_BEATS / 2)
				drain();
		end
		drain();
		repeat (2 * DEPTH + 10) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: filelist.f
src/kmrq_pkg.sv
src/kmrq_front.sv
src/kmrq_back.sv
src/keyed_message_retry_queue_core.sv
src/kmrq_checker.sv
verif/keyed_message_retry_queue_core_tb.sv
